@@ hdl/sbr_pkg.sv @@
`timescale 1ns / 1ps

package sbr_pkg;

    // Reorder window depth in bytes.
    localparam int CAPACITY = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = $clog2(2 * CAPACITY);

    localparam int POS_W    = 32;
    localparam int BYTE_W   = 8;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_END     = 2'd1,
        OP_CONSUME = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_END    = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // take the input transaction and apply its operation
        logic pop;          // deliver the byte at the head slot
        logic emit_end;     // emit the end-of-stream result
        logic emit_status;  // emit the closing status result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_mark;    // head slot holds a byte
        logic end_hit;      // end declared, not yet reported, and reached
        logic out_free;     // output register can take a result this cycle
    } t_sts;

endpackage

@@ hdl/sbr_ctrl.sv @@
`timescale 1ns / 1ps

module sbr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sbr_pkg::t_sts i_sts,
    output sbr_pkg::t_cmd o_cmd
);
    import sbr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DRAIN  = 3'b010,
        ST_STATUS = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.out_free) begin
                    if (i_sts.head_mark) begin
                        o_cmd.pop = 1'b1;
                    end else if (i_sts.end_hit) begin
                        o_cmd.emit_end = 1'b1;
                        n_state        = ST_STATUS;
                    end else begin
                        o_cmd.emit_status = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end
            end
            ST_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/sbr_dp.sv @@
`timescale 1ns / 1ps

module sbr_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbr_pkg::t_cmd               i_cmd,
    output sbr_pkg::t_sts               o_sts,
    input  logic [1:0]                  i_opcode,
    input  logic [sbr_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [sbr_pkg::POS_W-1:0]   i_position,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [1:0]                  o_kind,
    output logic [sbr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [sbr_pkg::POS_W-1:0]   o_out_position,
    output logic [5:0]                  o_pending_count,
    output logic                        o_is_empty,
    output logic                        o_last
);
    import sbr_pkg::*;

    logic [BYTE_W-1:0] r_bytes [CAPACITY];
    logic [CAPACITY-1:0] r_marks;
    logic [SLOT_W-1:0] r_head;
    logic [POS_W-1:0]  r_next;
    logic [POS_W-1:0]  r_consumed;
    logic [POS_W-1:0]  r_end_index;
    logic              r_end_known;
    logic              r_end_sent;
    logic [CNT_W-1:0]  r_pending;

    logic              r_out_valid;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_pos;
    logic [CNT_W-1:0]  r_out_pending;
    logic              r_out_last;

    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  used;
    logic [CNT_W-1:0]  room;
    logic              in_window;
    logic [SUM_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] slot;
    logic              do_store;
    logic [CNT_W-1:0]  pending_dec;
    logic [SLOT_W-1:0] head_inc;

    // Window test on wrapped distances; the slot index wraps once at most.
    always_comb begin
        offset    = i_position - r_next;
        used      = r_next - r_consumed;
        room      = (used < POS_W'(CAPACITY)) ? CNT_W'(POS_W'(CAPACITY) - used) : '0;
        in_window = (offset < POS_W'(room));
        slot_sum  = SUM_W'(r_head) + SUM_W'(offset[CNT_W-1:0]);
        slot      = (slot_sum >= SUM_W'(CAPACITY)) ? SLOT_W'(slot_sum - SUM_W'(CAPACITY))
                                                   : SLOT_W'(slot_sum);
        do_store  = i_cmd.load && (t_opcode'(i_opcode) == OP_PUSH) && in_window
                    && !r_marks[slot];
        pending_dec = (r_pending != '0) ? r_pending - CNT_W'(1) : '0;
        head_inc  = (r_head == SLOT_W'(CAPACITY - 1)) ? '0 : r_head + SLOT_W'(1);
    end

    assign o_sts.head_mark = r_marks[r_head];
    assign o_sts.end_hit   = r_end_known && !r_end_sent && (r_end_index == r_next);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_bytes[slot] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks     <= '0;
            r_head      <= '0;
            r_next      <= '0;
            r_consumed  <= '0;
            r_end_index <= '0;
            r_end_known <= 1'b0;
            r_end_sent  <= 1'b0;
            r_pending   <= '0;
        end else begin
            if (do_store) begin
                r_marks[slot] <= 1'b1;
                r_pending     <= r_pending + CNT_W'(1);
            end
            if (i_cmd.load && (t_opcode'(i_opcode) == OP_END)) begin
                r_end_index <= i_position;
                r_end_known <= 1'b1;
            end
            if (i_cmd.load && (t_opcode'(i_opcode) == OP_CONSUME) && (r_consumed != r_next)) begin
                r_consumed <= r_consumed + POS_W'(1);
            end
            if (i_cmd.pop) begin
                r_marks[r_head] <= 1'b0;
                r_head          <= head_inc;
                r_next          <= r_next + POS_W'(1);
                r_pending       <= pending_dec;
            end
            if (i_cmd.emit_end) begin
                r_end_sent <= 1'b1;
            end
        end
    end

    // Output register: one result waits here while the next is prepared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pop || i_cmd.emit_end || i_cmd.emit_status) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_kind        <= KIND_BYTE;
            r_out_byte    <= r_bytes[r_head];
            r_out_pos     <= r_next;
            r_out_pending <= pending_dec;
            r_out_last    <= 1'b0;
        end else if (i_cmd.emit_end || i_cmd.emit_status) begin
            r_kind        <= i_cmd.emit_end ? KIND_END : KIND_STATUS;
            r_out_byte    <= '0;
            r_out_pos     <= '0;
            r_out_pending <= r_pending;
            r_out_last    <= i_cmd.emit_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_out_byte;
    assign o_out_position  = r_out_pos;
    assign o_pending_count = 6'(r_out_pending);
    assign o_is_empty      = (r_out_pending == '0);
    assign o_last          = r_out_last;

endmodule

@@ hdl/stream_byte_reassembler_top.sv @@
`timescale 1ns / 1ps

// Byte-stream reassembler. Each input transaction carries one operation: push a
// byte at an absolute 32-bit stream position, declare the end position, or
// report that the reader took one delivered byte. Pushed bytes are kept in a
// 32-slot ring while they wait for earlier bytes, and every contiguous run that
// becomes complete is delivered in order, one result transaction per byte with
// its position. End of stream is reported once, when delivery reaches the
// declared end, and every input transaction closes with a status result (last
// set) that carries the count of stored but undelivered bytes. Each input is
// handled in order: the operation is applied, each deliverable byte is emitted,
// the end of stream is reported if due, and the status closes it; the single
// output register sets this pace, so an output stall holds it back. The input
// stall is high from the accepting edge until the status result has been loaded
// into the output register.

module stream_byte_reassembler_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [sbr_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic [sbr_pkg::POS_W-1:0]   i_position,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_kind,
    output logic [sbr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [sbr_pkg::POS_W-1:0]   o_out_position,
    output logic [5:0]                  o_pending_count,
    output logic                        o_is_empty,
    output logic                        o_last
);
    import sbr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller sequences apply, drain, end report and status.
    sbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the ring, the stream counters and the output register.
    sbr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .i_position      (i_position),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_out_position  (o_out_position),
        .o_pending_count (o_pending_count),
        .o_is_empty      (o_is_empty),
        .o_last          (o_last)
    );

endmodule
